### design/wcpf_pkg.sv
// ----------------------------------------------------------------------------
// wcpf_pkg
// Types and constants shared by the close pair finder modules.
// ----------------------------------------------------------------------------
`default_nettype none
package wcpf_pkg;

  localparam int unsigned IDX_W = 48;
  localparam int unsigned POS_W = 32;
  localparam int unsigned THR_W = 64;
  localparam int unsigned CFG_W = 64;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEP_SQ = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_GAP  = 1'd1;

  localparam logic [THR_W-1:0] MAX_SEP_SQ_RST = 64'd9663676416;
  localparam logic [IDX_W-1:0] INDEX_GAP_RST  = 48'd10000;

  typedef struct packed {
    logic [IDX_W-1:0] point_index;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] earlier_index;
    logic [IDX_W-1:0] later_index;
    logic             pair_found;
    logic             window_overflow;
    logic             last;
  } out_t;

  function automatic logic [POS_W-1:0] absdiff_pos(input logic [POS_W-1:0] a,
                                                   input logic [POS_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [IDX_W-1:0] absdiff_idx(input logic [IDX_W-1:0] a,
                                                   input logic [IDX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

endpackage
`default_nettype wire

### design/windowed_close_pair_finder_top.sv
// ----------------------------------------------------------------------------
// windowed_close_pair_finder_top
// Fixed-radius close pair search over a sliding window of stored points.
// ----------------------------------------------------------------------------
// Each point is checked against every window slot; an active slot passes
// through one shared 32x32 multiplier that forms the three squares in turn,
// and the slot memory is read one slot at a time. A result beat that waits on
// a stalled output holds the search. A two-entry input queue holds the point
// in process and accepts one further point, and one result beat is offered
// per pair, or one empty beat when none is found.
`default_nettype none
module windowed_close_pair_finder_top #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  wcpf_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output wcpf_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [wcpf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wcpf_pkg::CFG_W-1:0]      cfg_data_i
);
  import wcpf_pkg::*;

  logic q_valid, q_pop;
  in_t  q_data;

  wcpf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  wcpf_back #(.DEPTH(WINDOW_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule
`default_nettype wire

### design/wcpf_front.sv
// ----------------------------------------------------------------------------
// wcpf_front
// Accepts points and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module wcpf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  wcpf_pkg::in_t  in_data_i,
  output logic           q_valid_o,
  output wcpf_pkg::in_t  q_data_o,
  input  logic           q_pop_i
);
  import wcpf_pkg::*;

  in_t        buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (q_pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule
`default_nettype wire

### design/wcpf_back.sv
// ----------------------------------------------------------------------------
// wcpf_back
// Walks the window slot by slot, oldest first, computes the squared
// separation with one shared multiplier, and emits pairs.
// ----------------------------------------------------------------------------
`default_nettype none
module wcpf_back #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  wcpf_pkg::in_t                       q_data_i,
  output logic                                q_pop_o,
  input  logic                                cfg_we_i,
  input  logic [wcpf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wcpf_pkg::CFG_W-1:0]          cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output wcpf_pkg::out_t                      out_data_o
);
  import wcpf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_DIF  = 4'd2;
  localparam logic [3:0] S_MX   = 4'd3;
  localparam logic [3:0] S_MY   = 4'd4;
  localparam logic [3:0] S_MZ   = 4'd5;
  localparam logic [3:0] S_SUM  = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_WR   = 4'd8;
  localparam logic [3:0] S_FL   = 4'd9;

  in_t               mem_q [DEPTH];
  in_t               rd_q;
  logic [DEPTH-1:0]  active_q;
  logic [3:0]        st_q;
  logic [AW-1:0]     head_q, s_q, cnt_q;
  logic [POS_W-1:0]  dx_q, dy_q, dz_q;
  logic [IDX_W-1:0]  gd_q;
  logic [63:0]       prod_q;
  logic [65:0]       acc_q;
  logic              pend_v_q, ovf_q, out_v_q;
  logic [IDX_W-1:0]  pend_idx_q;
  out_t              out_q;
  logic [THR_W-1:0]  thr_q;
  logic [IDX_W-1:0]  gap_q;

  logic mem_re, mem_we, out_free, hit, ret, emit;

  assign mem_re   = (st_q == S_RD) && active_q[s_q];
  assign mem_we   = (st_q == S_WR);
  assign out_free = !out_v_q || !out_stall_i;
  assign hit      = acc_q < {2'b00, thr_q};
  assign ret      = gd_q > gap_q;
  assign q_pop_o  = (st_q == S_FL) && out_free;
  assign emit     = ((st_q == S_CMP) && hit && pend_v_q && out_free) ||
                    ((st_q == S_FL) && out_free);

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[head_q] <= q_data_i;
    end
    if (mem_re) begin
      rd_q <= mem_q[s_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      active_q   <= '0;
      head_q     <= '0;
      s_q        <= '0;
      cnt_q      <= '0;
      pend_v_q   <= 1'b0;
      ovf_q      <= 1'b0;
      out_v_q    <= 1'b0;
      thr_q      <= MAX_SEP_SQ_RST;
      gap_q      <= INDEX_GAP_RST;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_SEP_SQ: thr_q <= cfg_data_i;
          CFG_INDEX_GAP:  gap_q <= cfg_data_i[IDX_W-1:0];
          default: ;
        endcase
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && !out_stall_i) begin
        out_v_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (q_valid_i) begin
            s_q      <= head_q;
            cnt_q    <= '0;
            pend_v_q <= 1'b0;
            ovf_q    <= 1'b0;
            st_q     <= S_RD;
          end
        end
        S_RD: begin
          if (active_q[s_q]) begin
            st_q <= S_DIF;
          end else if (cnt_q == LAST_SLOT) begin
            st_q <= S_WR;
          end else begin
            cnt_q <= cnt_q + 1'b1;
            s_q   <= (s_q == LAST_SLOT) ? '0 : s_q + 1'b1;
          end
        end
        S_DIF: begin
          dx_q  <= absdiff_pos(rd_q.pos_x, q_data_i.pos_x);
          dy_q  <= absdiff_pos(rd_q.pos_y, q_data_i.pos_y);
          dz_q  <= absdiff_pos(rd_q.pos_z, q_data_i.pos_z);
          gd_q  <= absdiff_idx(rd_q.point_index, q_data_i.point_index);
          acc_q <= '0;
          st_q  <= S_MX;
        end
        S_MX: begin
          prod_q <= {32'd0, dx_q} * {32'd0, dx_q};
          st_q   <= S_MY;
        end
        S_MY: begin
          acc_q  <= acc_q + {2'b00, prod_q};
          prod_q <= {32'd0, dy_q} * {32'd0, dy_q};
          st_q   <= S_MZ;
        end
        S_MZ: begin
          acc_q  <= acc_q + {2'b00, prod_q};
          prod_q <= {32'd0, dz_q} * {32'd0, dz_q};
          st_q   <= S_SUM;
        end
        S_SUM: begin
          acc_q <= acc_q + {2'b00, prod_q};
          st_q  <= S_CMP;
        end
        S_CMP: begin
          // A held pair can only go out once we know it is not the last one.
          if (!(hit && pend_v_q && !out_free)) begin
            if (hit) begin
              if (pend_v_q) begin
                out_q   <= '{earlier_index: pend_idx_q,
                             later_index: q_data_i.point_index,
                             pair_found: 1'b1, window_overflow: ovf_q, last: 1'b0};
              end
              pend_v_q   <= 1'b1;
              pend_idx_q <= rd_q.point_index;
            end
            if (ret) begin
              active_q[s_q] <= 1'b0;
            end
            // The head slot, when active, is compared first, so its fate fixes the overflow flag.
            if (cnt_q == '0) begin
              ovf_q <= !ret;
            end
            if (cnt_q == LAST_SLOT) begin
              st_q <= S_WR;
            end else begin
              cnt_q <= cnt_q + 1'b1;
              s_q   <= (s_q == LAST_SLOT) ? '0 : s_q + 1'b1;
              st_q  <= S_RD;
            end
          end
        end
        S_WR: begin
          active_q[head_q] <= 1'b1;
          head_q <= (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
          st_q   <= S_FL;
        end
        S_FL: begin
          if (out_free) begin
            out_q   <= '{earlier_index: pend_v_q ? pend_idx_q : '0,
                         later_index: q_data_i.point_index,
                         pair_found: pend_v_q, window_overflow: ovf_q, last: 1'b1};
            st_q    <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/wcpf_checker.sv
// ----------------------------------------------------------------------------
// wcpf_checker
// Port-level checks for the close pair finder.
// ----------------------------------------------------------------------------
`default_nettype none
module wcpf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input wcpf_pkg::in_t                   in_data_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input wcpf_pkg::out_t                  out_data_o,
  input logic                            cfg_we_i,
  input logic [wcpf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [wcpf_pkg::CFG_W-1:0]      cfg_data_i
);
  import wcpf_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.pair_found |-> out_data_o.last
      && out_data_o.earlier_index == '0)
    else $error("empty result is not a lone final beat");

  // Overflow is a property of the whole point, so it cannot change mid-burst.
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last ##1 out_valid_o
      |-> out_data_o.window_overflow == $past(out_data_o.window_overflow))
    else $error("overflow flag changed within one point's results");

  a_later_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last ##1 out_valid_o
      |-> out_data_o.later_index == $past(out_data_o.later_index))
    else $error("later index changed within one point's results");
endmodule

bind windowed_close_pair_finder_top wcpf_checker u_wcpf_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
  .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
);
`default_nettype wire
